// ===== src/bmg_pkg.sv =====
`timescale 1ns / 1ps

package bmg_pkg;

   // Default store geometry
   localparam int MAIN_BYTES_DEFAULT   = 65536;
   localparam int SHADOW_BYTES_DEFAULT = 20;

   // Access codes on req_func
   localparam logic [1:0] FUNC_READ_LO = 2'd0;
   localparam logic [1:0] FUNC_READ_HI = 2'd1;
   localparam logic [1:0] FUNC_WRITE   = 2'd2;
   localparam logic [1:0] FUNC_NONE    = 2'd3;

   // GPIO window addresses
   localparam logic [31:0] WIN_PINS_LOW  = 32'h2020_0000;
   localparam logic [31:0] WIN_PINS_MID  = 32'h2020_0004;
   localparam logic [31:0] WIN_PINS_HIGH = 32'h2020_0008;
   localparam logic [31:0] WIN_CLEAR     = 32'h2020_0028;
   localparam logic [31:0] WIN_SET       = 32'h2020_001c;

   // Shadow area offsets past main memory
   localparam logic [31:0] SHADOW_PINS_LOW  = 32'h0000_0000;
   localparam logic [31:0] SHADOW_PINS_MID  = 32'h0000_0004;
   localparam logic [31:0] SHADOW_PINS_HIGH = 32'h0000_0008;
   localparam logic [31:0] SHADOW_CLEAR     = 32'h0000_000c;
   localparam logic [31:0] SHADOW_SET       = 32'h0000_0010;

   // Region codes on rsp_gpio_region
   localparam logic [2:0] REGION_NONE      = 3'd0;
   localparam logic [2:0] REGION_PINS_LOW  = 3'd1;
   localparam logic [2:0] REGION_PINS_MID  = 3'd2;
   localparam logic [2:0] REGION_PINS_HIGH = 3'd3;
   localparam logic [2:0] REGION_CLEAR     = 3'd4;
   localparam logic [2:0] REGION_SET       = 3'd5;

   // What the back end does with a queued access
   typedef enum logic [2:0] {
      OP_NONE,
      OP_READ_LO,
      OP_READ_HI,
      OP_WRITE,
      OP_ADDR
   } op_type;

   // One classified access
   typedef struct packed {
      op_type      op;
      logic [31:0] base;
      logic [31:0] data;
      logic        oob;
      logic [2:0]  region;
   } entry_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// ===== src/bmg_front.sv =====
`timescale 1ns / 1ps

module bmg_front #(
   parameter int MAIN_BYTES = bmg_pkg::MAIN_BYTES_DEFAULT
) (
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [31:0]         req_address,
   input  logic [31:0]         req_write_data,
   input  logic                queue_full,
   input  logic                clear_busy,
   output logic                push,
   output bmg_pkg::entry_type  push_entry
);
   import bmg_pkg::*;

   logic        in_win;
   logic [2:0]  win_region;
   logic [31:0] win_base;

   // Take a beat only when the queue has room and the store is cleared
   assign req_ready = !queue_full && !clear_busy && !reset;
   assign push      = req_valid && req_ready;

   // Decode the GPIO window
   always_comb begin
      in_win = ((req_address >= WIN_PINS_LOW) && (req_address <= WIN_PINS_HIGH))
               || (req_address == WIN_CLEAR) || (req_address == WIN_SET);
      case (req_address)
         WIN_PINS_LOW: begin
            win_region = REGION_PINS_LOW;
            win_base   = 32'(MAIN_BYTES) + SHADOW_PINS_LOW;
         end
         WIN_PINS_MID: begin
            win_region = REGION_PINS_MID;
            win_base   = 32'(MAIN_BYTES) + SHADOW_PINS_MID;
         end
         WIN_PINS_HIGH: begin
            win_region = REGION_PINS_HIGH;
            win_base   = 32'(MAIN_BYTES) + SHADOW_PINS_HIGH;
         end
         WIN_CLEAR: begin
            win_region = REGION_CLEAR;
            win_base   = 32'(MAIN_BYTES) + SHADOW_CLEAR;
         end
         WIN_SET: begin
            win_region = REGION_SET;
            win_base   = 32'(MAIN_BYTES) + SHADOW_SET;
         end
         default: begin
            // unlisted window address lands on store byte 0
            win_region = REGION_NONE;
            win_base   = '0;
         end
      endcase
   end

   // Classify the access for the back end
   always_comb begin
      push_entry.op     = OP_NONE;
      push_entry.base   = in_win ? win_base : req_address;
      push_entry.data   = req_write_data;
      push_entry.oob    = 1'b0;
      push_entry.region = REGION_NONE;
      if (req_func != FUNC_NONE) begin
         push_entry.region = in_win ? win_region : REGION_NONE;
         if (!in_win && (req_address >= 32'(MAIN_BYTES))) begin
            push_entry.oob = 1'b1;
         end else begin
            case (req_func)
               FUNC_READ_LO: begin
                  if (in_win) begin
                     push_entry.op   = OP_ADDR;
                     push_entry.data = req_address;
                  end else begin
                     push_entry.op = OP_READ_LO;
                  end
               end
               FUNC_READ_HI: push_entry.op = OP_READ_HI;
               FUNC_WRITE:   push_entry.op = OP_WRITE;
               default:      push_entry.op = OP_NONE;
            endcase
         end
      end
   end

endmodule

// ===== src/bmg_queue.sv =====
`timescale 1ns / 1ps

module bmg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bmg_pkg::entry_type push_entry,
   output logic               queue_full,
   input  logic               pop,
   output bmg_pkg::head_type  head
);
   import bmg_pkg::*;

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign queue_full  = (count_ff == 2'd2);
   assign head.valid  = (count_ff != 2'd0);
   assign head.entry  = slots_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload in the slots
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/bmg_back.sv =====
`timescale 1ns / 1ps

module bmg_back #(
   parameter int MAIN_BYTES   = bmg_pkg::MAIN_BYTES_DEFAULT,
   parameter int SHADOW_BYTES = bmg_pkg::SHADOW_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  bmg_pkg::head_type head,
   output logic              pop,
   output logic              clear_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_read_data,
   output logic              rsp_out_of_bounds,
   output logic [2:0]        rsp_gpio_region
);
   import bmg_pkg::*;

   localparam int STORE_BYTES = MAIN_BYTES + SHADOW_BYTES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int ROW_W       = ADDR_W - 2;
   localparam int LANE_ROWS   = (STORE_BYTES + 3) / 4;

   // Clear sweep
   logic             clr_busy_ff, clr_busy_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;

   // Memory lanes, one byte each
   logic [ROW_W-1:0] base_row;
   logic [1:0]       base_off;
   logic [ROW_W-1:0] lane_row   [4];
   logic [1:0]       lane_idx   [4];
   logic [7:0]       lane_wbyte [4];
   logic [3:0]       lane_we;
   logic             lane_re;
   logic [7:0]       lane_rdata_ff [4];

   // Issue and result stages
   logic        issue;
   logic        s1_move;
   logic        s1_valid_ff, s1_valid_in;
   op_type      s1_op_ff;
   logic [1:0]  s1_off_ff;
   logic [31:0] s1_data_ff;
   logic        s1_oob_ff;
   logic [2:0]  s1_region_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff, out_data_in;
   logic        out_oob_ff;
   logic [2:0]  out_region_ff;
   logic [31:0] lo_word, hi_word;
   logic [1:0]  src_lane;

   assign clear_busy = clr_busy_ff;

   // Walk every row once after reset, writing zero
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + ROW_W'(1);
         if (clr_row_ff == ROW_W'(LANE_ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   // Stage flow
   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign issue   = head.valid && !clr_busy_ff && (!s1_valid_ff || s1_move);
   assign pop     = issue;

   // Spread the word over the four lanes
   assign base_row = head.entry.base[ADDR_W-1:2];
   assign base_off = head.entry.base[1:0];
   assign lane_re  = issue && ((head.entry.op == OP_READ_LO) || (head.entry.op == OP_READ_HI));

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         lane_idx[l] = 2'(l) - base_off;
         if (clr_busy_ff) begin
            lane_row[l]   = clr_row_ff;
            lane_wbyte[l] = 8'h00;
            lane_we[l]    = 1'b1;
         end else begin
            lane_row[l]   = base_row + ROW_W'(2'(l) < base_off);
            lane_wbyte[l] = head.entry.data[{lane_idx[l], 3'b000} +: 8];
            lane_we[l]    = issue && (head.entry.op == OP_WRITE);
         end
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [7:0] mem [LANE_ROWS];

      always_ff @(posedge clock) begin
         if (lane_we[l]) begin
            mem[lane_row[l]] <= lane_wbyte[l];
         end
         if (lane_re) begin
            lane_rdata_ff[l] <= mem[lane_row[l]];
         end
      end
   end

   // Track the access while the lanes read
   assign s1_valid_in = issue || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_op_ff     <= head.entry.op;
         s1_off_ff    <= base_off;
         s1_data_ff   <= head.entry.data;
         s1_oob_ff    <= head.entry.oob;
         s1_region_ff <= head.entry.region;
      end
   end

   // Assemble the word in either byte order, or pass on the echoed address
   always_comb begin
      lo_word  = '0;
      hi_word  = '0;
      src_lane = '0;
      for (int i = 0; i < 4; i++) begin
         src_lane                = s1_off_ff + 2'(i);
         lo_word[8*i +: 8]       = lane_rdata_ff[src_lane];
         hi_word[8*(3-i) +: 8]   = lane_rdata_ff[src_lane];
      end
      case (s1_op_ff)
         OP_READ_LO: out_data_in = lo_word;
         OP_READ_HI: out_data_in = hi_word;
         OP_ADDR:    out_data_in = s1_data_ff;
         default:    out_data_in = '0;
      endcase
   end

   // Output register: hold until the beat is taken
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_data_ff   <= out_data_in;
         out_oob_ff    <= s1_oob_ff;
         out_region_ff <= s1_region_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_data_ff;
   assign rsp_out_of_bounds = out_oob_ff;
   assign rsp_gpio_region   = out_region_ff;

endmodule

// ===== src/byte_memory_with_gpio_window.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   req_func, req_address, req_write_data
// rsp      out        rsp_valid/rsp_ready   rsp_read_data, rsp_out_of_bounds,
//                                           rsp_gpio_region
//
// One access per cycle sustained once the clear sweep is done and while rsp_ready
// stays high; each access passes the queue slot, lane memory read and output register.
// The store is four byte-wide lane memories with one port each; a word at any
// byte offset touches each lane once.
// After reset the lanes are swept to zero, one row per cycle, over all
// ceil((MAIN_BYTES + SHADOW_BYTES) / 4) rows (16389 by default); req_ready
// stays low meanwhile.
// A two-entry queue parts classification from execution, so a stalled
// response stalls the request side only once the queue is full.

module byte_memory_with_gpio_window #(
   parameter int MAIN_BYTES   = bmg_pkg::MAIN_BYTES_DEFAULT,
   parameter int SHADOW_BYTES = bmg_pkg::SHADOW_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_out_of_bounds,
   output logic [2:0]  rsp_gpio_region
);
   import bmg_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   head_type  head;
   logic      clear_busy;

   bmg_front #(
      .MAIN_BYTES (MAIN_BYTES)
   ) u_front (
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .queue_full     (queue_full),
      .clear_busy     (clear_busy),
      .push           (push),
      .push_entry     (push_entry)
   );

   bmg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full),
      .pop        (pop),
      .head       (head)
   );

   bmg_back #(
      .MAIN_BYTES   (MAIN_BYTES),
      .SHADOW_BYTES (SHADOW_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .clear_busy        (clear_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_out_of_bounds (rsp_out_of_bounds),
      .rsp_gpio_region   (rsp_gpio_region)
   );

endmodule

// ===== src/bmg_checker.sv =====
`timescale 1ns / 1ps

module bmg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_func,
   input logic [31:0] req_address,
   input logic [31:0] req_write_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic        rsp_out_of_bounds,
   input logic [2:0]  rsp_gpio_region
);
   import bmg_pkg::*;

   // A waiting request beat holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_func)
         && $stable(req_address) && $stable(req_write_data))
      else $error("request beat changed while waiting");

   // A stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_out_of_bounds) && $stable(rsp_gpio_region))
      else $error("response beat changed while stalled");

   // Out of bounds reads back zero and lies outside the window
   a_oob_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_bounds |-> (rsp_read_data == 32'h0)
         && (rsp_gpio_region == REGION_NONE))
      else $error("out-of-bounds beat carries data or region");

   // Region code stays within its defined range
   a_region_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gpio_region <= REGION_SET))
      else $error("undefined region code");

   // Right after reset the store is still being cleared and nothing is pending
   a_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready && !rsp_valid)
      else $error("block active right after reset");

endmodule

bind byte_memory_with_gpio_window bmg_checker u_checker (.*);

// ===== tb/sv/byte_memory_with_gpio_window_test.sv =====
`timescale 1ns / 1ps

module byte_memory_with_gpio_window_test;
   import bmg_pkg::*;

   localparam logic [31:0] MAIN_LIMIT  = MAIN_BYTES_DEFAULT;
   localparam int          STORE_BYTES = MAIN_BYTES_DEFAULT + SHADOW_BYTES_DEFAULT;

   typedef struct packed {
      logic [31:0] read_data;
      logic        out_of_bounds;
      logic [2:0]  gpio_region;
   } access_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FUNC_NONE;
   logic [31:0] req_address = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_out_of_bounds;
   logic [2:0]  rsp_gpio_region;

   // Shadow copy of main memory plus GPIO shadow area
   logic [7:0]        mem_bytes [0:STORE_BYTES-1];
   access_result_type pending_results [$];
   int                mismatches   = 0;
   int                req_idle_pct = 10;
   int                rsp_idle_pct = 10;
   int                stall_left   = 0;

   byte_memory_with_gpio_window dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_out_of_bounds (rsp_out_of_bounds),
      .rsp_gpio_region   (rsp_gpio_region)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Perform one access on the shadow store and return the reply it should give
   function automatic access_result_type apply_access(input logic [1:0] func,
         input logic [31:0] addr, input logic [31:0] wdata);
      access_result_type res;
      logic [31:0]       base;
      logic              in_win;
      int                i;
      res    = '0;
      base   = addr;
      in_win = (addr >= WIN_PINS_LOW && addr <= WIN_PINS_HIGH) ||
               addr == WIN_CLEAR || addr == WIN_SET;
      if (func == FUNC_NONE)
         return res;
      // classify: window maps to shadow, anything else past main memory is out
      if (in_win) begin
         case (addr)
            WIN_PINS_LOW: begin
               res.gpio_region = REGION_PINS_LOW;
               base = MAIN_LIMIT + SHADOW_PINS_LOW;
            end
            WIN_PINS_MID: begin
               res.gpio_region = REGION_PINS_MID;
               base = MAIN_LIMIT + SHADOW_PINS_MID;
            end
            WIN_PINS_HIGH: begin
               res.gpio_region = REGION_PINS_HIGH;
               base = MAIN_LIMIT + SHADOW_PINS_HIGH;
            end
            WIN_CLEAR: begin
               res.gpio_region = REGION_CLEAR;
               base = MAIN_LIMIT + SHADOW_CLEAR;
            end
            WIN_SET: begin
               res.gpio_region = REGION_SET;
               base = MAIN_LIMIT + SHADOW_SET;
            end
            default: base = '0;
         endcase
      end else if (addr >= MAIN_LIMIT) begin
         res.out_of_bounds = 1'b1;
      end
      if (!res.out_of_bounds) begin
         case (func)
            FUNC_READ_LO: begin
               if (in_win)
                  res.read_data = addr;
               else
                  for (i = 0; i < 4; i++)
                     res.read_data[8*i +: 8] = mem_bytes[base + i];
            end
            FUNC_READ_HI: begin
               for (i = 0; i < 4; i++)
                  res.read_data[24 - 8*i +: 8] = mem_bytes[base + i];
            end
            FUNC_WRITE: begin
               for (i = 0; i < 4; i++)
                  mem_bytes[base + i] = wdata[8*i +: 8];
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   // Check response beats against predictions, then predict each request beat
   always @(posedge clock) begin : track_beats
      access_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("response beat with no access outstanding");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, actual %h", want.read_data, rsp_read_data);
                  mismatches++;
               end
               if (rsp_out_of_bounds !== want.out_of_bounds) begin
                  $error("out_of_bounds: expected %b, actual %b",
                         want.out_of_bounds, rsp_out_of_bounds);
                  mismatches++;
               end
               if (rsp_gpio_region !== want.gpio_region) begin
                  $error("gpio_region: expected %0d, actual %0d",
                         want.gpio_region, rsp_gpio_region);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(apply_access(req_func, req_address, req_write_data));
      end
   end

   // Drive response ready: long hold-off on request, otherwise random idling
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offer one access and hold it until its beat
   task automatic send_access(input logic [1:0] func, input logic [31:0] addr,
         input logic [31:0] wdata);
      if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_address    <= addr;
      req_write_data <= wdata;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait for every outstanding reply
   task automatic stop_and_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_access();
      int          pick;
      logic [1:0]  func;
      logic [31:0] addr;
      pick = $urandom_range(99);
      func = 2'($urandom_range(2));
      if (pick < 30)
         addr = $urandom_range(255);
      else if (pick < 45)
         addr = MAIN_LIMIT - 1 - $urandom_range(7);
      else if (pick < 60)
         addr = $urandom_range(MAIN_LIMIT - 1);
      else if (pick < 75) begin
         case ($urandom_range(5))
            0: addr = WIN_PINS_LOW;
            1: addr = WIN_PINS_MID;
            2: addr = WIN_PINS_HIGH;
            3: addr = WIN_CLEAR;
            4: addr = WIN_SET;
            default: addr = WIN_PINS_LOW + $urandom_range(1, 7);
         endcase
      end else if (pick < 85)
         addr = $urandom;
      else if (pick < 95)
         addr = $urandom_range(1) ? MAIN_LIMIT + $urandom_range(15)
                                  : WIN_PINS_LOW + $urandom_range(63);
      else begin
         func = FUNC_NONE;
         addr = $urandom;
      end
      send_access(func, addr, $urandom);
   endtask

   task automatic test_word_order();
      send_access(FUNC_WRITE, 32'h0000_0000, 32'h1122_3344);
      send_access(FUNC_READ_LO, 32'h0000_0000, 32'h0);
      send_access(FUNC_READ_HI, 32'h0000_0000, 32'h0);
      stop_and_drain();
   endtask

   // Word at the top of main memory spills into the shadow area
   task automatic test_top_of_main();
      send_access(FUNC_WRITE, MAIN_LIMIT - 1, 32'hA1B2_C3D4);
      send_access(FUNC_READ_LO, MAIN_LIMIT - 1, 32'h0);
      send_access(FUNC_READ_HI, WIN_PINS_LOW, 32'h0);
      stop_and_drain();
   endtask

   task automatic test_gpio_window();
      send_access(FUNC_WRITE, WIN_PINS_LOW, 32'hFFFF_FFFF);
      send_access(FUNC_WRITE, WIN_PINS_MID, 32'h0000_0000);
      send_access(FUNC_WRITE, WIN_PINS_HIGH, 32'h8765_4321);
      send_access(FUNC_WRITE, WIN_CLEAR, 32'h5A5A_A5A5);
      send_access(FUNC_WRITE, WIN_SET, 32'hDEAD_BEEF);
      send_access(FUNC_READ_HI, WIN_PINS_MID, 32'h0);
      send_access(FUNC_READ_HI, WIN_SET, 32'h0);
      send_access(FUNC_READ_LO, WIN_CLEAR, 32'h0);
      // unlisted window addresses fall onto byte 0 or echo the address
      send_access(FUNC_WRITE, WIN_PINS_LOW + 3, 32'hCAFE_F00D);
      send_access(FUNC_READ_HI, WIN_PINS_LOW + 1, 32'h0);
      send_access(FUNC_READ_LO, WIN_PINS_LOW + 7, 32'h0);
      stop_and_drain();
   endtask

   task automatic test_out_of_bounds();
      send_access(FUNC_WRITE, MAIN_LIMIT, 32'hFFFF_FFFF);
      send_access(FUNC_READ_LO, MAIN_LIMIT, 32'h0);
      send_access(FUNC_READ_HI, 32'hFFFF_FFFF, 32'h0);
      send_access(FUNC_READ_LO, 32'h8000_0000, 32'h0);
      send_access(FUNC_READ_LO, WIN_PINS_HIGH + 1, 32'h0);
      stop_and_drain();
   endtask

   task automatic test_no_access();
      send_access(FUNC_NONE, WIN_PINS_LOW, 32'hFFFF_FFFF);
      send_access(FUNC_NONE, 32'h0000_0000, 32'h1234_5678);
      stop_and_drain();
   endtask

   task automatic test_random_mix();
      int n;
      for (n = 0; n < 1500; n++)
         send_random_access();
      stop_and_drain();
   endtask

   // Full rate on both sides, no idling at all
   task automatic test_back_to_back();
      int n;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (n = 0; n < 300; n++)
         send_random_access();
      stop_and_drain();
      req_idle_pct = 10;
      rsp_idle_pct = 10;
   endtask

   // Hold off responses long enough for the queue to fill and stall requests
   task automatic test_response_stall();
      int n;
      req_idle_pct = 0;
      stall_left   = 400;
      for (n = 0; n < 60; n++)
         send_random_access();
      stop_and_drain();
      req_idle_pct = 10;
   endtask

   initial begin
      foreach (mem_bytes[i])
         mem_bytes[i] = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_word_order();
      test_top_of_main();
      test_gpio_window();
      test_out_of_bounds();
      test_no_access();
      test_random_mix();
      test_back_to_back();
      test_response_stall();
      // let any stray beat show up before judging
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== byte_memory_with_gpio_window.f =====
src/bmg_pkg.sv
src/bmg_front.sv
src/bmg_queue.sv
src/bmg_back.sv
src/byte_memory_with_gpio_window.sv
src/bmg_checker.sv
tb/sv/byte_memory_with_gpio_window_test.sv
